>>> hdl/dhco_pkg.sv
// Package: types, constants and helper functions for the DH chain orientation block.
package dhco_pkg;
	localparam int NUM_LINKS_DEF  = 5;
	localparam int ANGLE_BITS     = 16;
	localparam int LINK_FIELDS    = 5;
	localparam int CORDIC_STEPS   = 16;
	localparam int IDX_BITS       = 3;
	localparam int XW             = 34;
	localparam int ZW             = 29;
	localparam logic signed [ZW-1:0] PI_Q24      = 29'sd52707179;
	localparam logic signed [ZW-1:0] HALF_PI_Q24 = 29'sd26353589;
	localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [16:0]   ONE_Q14     = 17'sd16384;

	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		logic signed [15:0] joint_1;
		logic signed [15:0] joint_2;
		logic signed [15:0] joint_3;
		logic signed [15:0] joint_4;
		logic signed [15:0] joint_5;
	} in_word_t;

	typedef struct packed {
		q14_t rot_r0c0; q14_t rot_r0c1; q14_t rot_r0c2;
		q14_t rot_r1c0; q14_t rot_r1c1; q14_t rot_r1c2;
		q14_t rot_r2c0; q14_t rot_r2c1; q14_t rot_r2c2;
	} out_word_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] index;
		logic [15:0]         data;
	} cfg_word_t;

	typedef q14_t mat_t [3][3];

	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		case (i)
			0: return 29'sd13176795;
			1: return 29'sd7778716;
			2: return 29'sd4110060;
			3: return 29'sd2086331;
			4: return 29'sd1047214;
			5: return 29'sd524117;
			6: return 29'sd262123;
			7: return 29'sd131069;
			8: return 29'sd65536;
			9: return 29'sd32768;
			10: return 29'sd16384;
			11: return 29'sd8192;
			12: return 29'sd4096;
			13: return 29'sd2048;
			14: return 29'sd1024;
			default: return 29'sd512;
		endcase
	endfunction

	function automatic q14_t sat_one(input logic signed [35:0] v);
		if (v > 36'sd16384) return 16'sd16384;
		if (v < -36'sd16384) return -16'sd16384;
		return v[15:0];
	endfunction

	function automatic q14_t mul_q14(input q14_t a, input q14_t b);
		logic signed [35:0] p;
		p = 36'(a) * 36'(b) + 36'sd8192;
		return sat_one(p >>> 14);
	endfunction
endpackage

>>> hdl/dhco_cordic.sv
// Pipelined rotation-mode CORDIC giving Q1.14 cosine and sine of one angle.
module dhco_cordic import dhco_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ANGLE_BITS-1:0] angle,
	output q14_t                         cos_o,
	output q14_t                         sin_o
);
	logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
	logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
	logic                 f_q [CORDIC_STEPS+1];
	logic signed [ZW-1:0] zw;
	logic signed [XW-1:0] xr, yr;

	assign zw = ZW'(angle) <<< (27 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= GAIN_Q30;
			y_q[0] <= '0;
			if (zw > HALF_PI_Q24) begin
				z_q[0] <= zw - PI_Q24; f_q[0] <= 1'b1;
			end else if (zw < -HALF_PI_Q24) begin
				z_q[0] <= zw + PI_Q24; f_q[0] <= 1'b1;
			end else begin
				z_q[0] <= zw; f_q[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				f_q[i+1] <= f_q[i];
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_q24(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_q24(i);
				end
			end
		end
	end

	assign xr = (x_q[CORDIC_STEPS] + XW'(32768)) >>> 16;
	assign yr = (y_q[CORDIC_STEPS] + XW'(32768)) >>> 16;

	always_comb begin
		cos_o = sat_one(36'(xr));
		sin_o = sat_one(36'(yr));
		if (f_q[CORDIC_STEPS]) begin
			cos_o = -cos_o;
			sin_o = -sin_o;
		end
	end
endmodule

>>> hdl/dhco_lane.sv
// One link lane: joint and twist CORDICs, then the link rotation matrix.
module dhco_lane import dhco_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [ANGLE_BITS-1:0] joint,
	input  logic signed [ANGLE_BITS-1:0] twist,
	output mat_t                         link
);
	q14_t ct, st, ca, sa;

	dhco_cordic u_jt (
		.clk(clk), .en(en), .angle(joint), .cos_o(ct), .sin_o(st));
	dhco_cordic u_tw (
		.clk(clk), .en(en), .angle(twist), .cos_o(ca), .sin_o(sa));

	always_ff @(posedge clk) begin
		if (en) begin
			link[0][0] <= ct;
			link[0][1] <= -st;
			link[0][2] <= '0;
			link[1][0] <= mul_q14(st, ca);
			link[1][1] <= mul_q14(ct, ca);
			link[1][2] <= -sa;
			link[2][0] <= mul_q14(st, sa);
			link[2][1] <= mul_q14(ct, sa);
			link[2][2] <= ca;
		end
	end
endmodule

>>> hdl/dhco_merge.sv
// Merge stage: one registered 3x3 matrix product; the top level delays the link matrices of later stages.
module dhco_merge import dhco_pkg::*; (
	input  logic clk,
	input  logic en,
	input  mat_t acc,
	input  mat_t link,
	output mat_t prod
);
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod[r][c] <= sat_one(36'(acc[r][0]) * 36'(link[0][c])
						+ 36'(acc[r][1]) * 36'(link[1][c])
						+ 36'(acc[r][2]) * 36'(link[2][c]) + 36'sd8192 >>> 14);
		end
	end
endmodule

>>> hdl/dh_chain_orientation.sv
// Top level: DH chain orientation, parallel link lanes and a matrix product chain.
// Throughput: one word per cycle; the whole pipeline advances when the output
// register is empty or taken.
// Reset: arst_n clears valid flags and loads the twist registers with their defaults.
module dh_chain_orientation import dhco_pkg::*; #(
	parameter int NUM_LINKS  = NUM_LINKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_word_t cfg_data
);
	localparam int NL    = (NUM_LINKS < LINK_FIELDS) ? NUM_LINKS : LINK_FIELDS;
	localparam int DEPTH = CORDIC_STEPS + 2 + NL;

	logic [15:0] twist_q [LINK_FIELDS];
	logic [15:0] joints [LINK_FIELDS];
	logic [DEPTH-1:0] vld_q;
	logic en;
	mat_t links [NL];
	mat_t chain [NL+1];
	mat_t dly [NL][NL];

	assign joints[0] = in_data.joint_1;
	assign joints[1] = in_data.joint_2;
	assign joints[2] = in_data.joint_3;
	assign joints[3] = in_data.joint_4;
	assign joints[4] = in_data.joint_5;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twist_q[0] <= 16'd0;
			twist_q[1] <= 16'd12868;
			twist_q[2] <= 16'd0;
			twist_q[3] <= 16'd0;
			twist_q[4] <= 16'd12868;
			vld_q      <= '0;
		end else begin
			if (cfg_valid && cfg_data.index < IDX_BITS'(LINK_FIELDS))
				twist_q[cfg_data.index] <= cfg_data.data;
			if (en) vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				chain[0][r][c] = (r == c) ? 16'sd16384 : 16'sd0;
	end

	for (genvar i = 0; i < NL; i++) begin : g_lane
		dhco_lane u_lane (
			.clk(clk), .en(en),
			.joint(joints[i][ANGLE_BITS-1:0]),
			.twist(twist_q[i][ANGLE_BITS-1:0]),
			.link(dly[i][0]));
		for (genvar d = 1; d <= i; d++) begin : g_dly
			always_ff @(posedge clk) if (en) dly[i][d] <= dly[i][d-1];
		end
		assign links[i] = dly[i][i];
		dhco_merge u_merge (
			.clk(clk), .en(en), .acc(chain[i]), .link(links[i]), .prod(chain[i+1]));
	end

	assign out_data = '{chain[NL][0][0], chain[NL][0][1], chain[NL][0][2],
		chain[NL][1][0], chain[NL][1][1], chain[NL][1][2],
		chain[NL][2][0], chain[NL][2][1], chain[NL][2][2]};
endmodule

>>> bench/dh_chain_orientation_test.sv
// Testbench for dh_chain_orientation: joint-angle stimulus, twist writes, orientation scoreboard.
`timescale 1ns / 1ps

class orient_board;
	dhco_pkg::out_word_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	function void note_angles(dhco_pkg::out_word_t w);
		pending = {pending, w};
	endfunction

	function void check_matrix(dhco_pkg::out_word_t got);
		dhco_pkg::out_word_t e;
		if (pending.size() == 0) begin
			$error("unexpected output word %h", got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.rot_r0c0 !== e.rot_r0c0) begin
			$error("rot_r0c0 exp %0d got %0d", e.rot_r0c0, got.rot_r0c0); errors++; end
		if (got.rot_r0c1 !== e.rot_r0c1) begin
			$error("rot_r0c1 exp %0d got %0d", e.rot_r0c1, got.rot_r0c1); errors++; end
		if (got.rot_r0c2 !== e.rot_r0c2) begin
			$error("rot_r0c2 exp %0d got %0d", e.rot_r0c2, got.rot_r0c2); errors++; end
		if (got.rot_r1c0 !== e.rot_r1c0) begin
			$error("rot_r1c0 exp %0d got %0d", e.rot_r1c0, got.rot_r1c0); errors++; end
		if (got.rot_r1c1 !== e.rot_r1c1) begin
			$error("rot_r1c1 exp %0d got %0d", e.rot_r1c1, got.rot_r1c1); errors++; end
		if (got.rot_r1c2 !== e.rot_r1c2) begin
			$error("rot_r1c2 exp %0d got %0d", e.rot_r1c2, got.rot_r1c2); errors++; end
		if (got.rot_r2c0 !== e.rot_r2c0) begin
			$error("rot_r2c0 exp %0d got %0d", e.rot_r2c0, got.rot_r2c0); errors++; end
		if (got.rot_r2c1 !== e.rot_r2c1) begin
			$error("rot_r2c1 exp %0d got %0d", e.rot_r2c1, got.rot_r2c1); errors++; end
		if (got.rot_r2c2 !== e.rot_r2c2) begin
			$error("rot_r2c2 exp %0d got %0d", e.rot_r2c2, got.rot_r2c2); errors++; end
	endfunction
endclass

module dh_chain_orientation_test;
	import dhco_pkg::*;

	localparam int TWIST_COUNT = 5;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_word_t cfg_data = '0;

	orient_board board;
	logic signed [15:0] twist[TWIST_COUNT];
	bit quiet = 1'b0;
	bit hold_out = 1'b0;

	dh_chain_orientation uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic longint q14_product(longint a, longint b);
		return clamp_unit(floor_shift(a * b + 8192, 14));
	endfunction

	function automatic void cordic_sincos(logic signed [15:0] ang, output longint c,
			output longint s);
		longint x, y, z, t;
		bit flip;
		longint steps[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
		x = 652032874;
		y = 0;
		z = longint'(ang) * 2048;
		flip = 1'b0;
		if (z > 26353589) begin
			z -= 52707179; flip = 1'b1;
		end else if (z < -26353589) begin
			z += 52707179; flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				t = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= steps[i];
			end else begin
				t = x + floor_shift(y, i); y = y - floor_shift(x, i); z += steps[i];
			end
			x = t;
		end
		x = clamp_unit(floor_shift(x + 32768, 16));
		y = clamp_unit(floor_shift(y + 32768, 16));
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic out_word_t chain_orientation(in_word_t a);
		longint acc[3][3], lk[3][3], nx[3][3];
		longint ct, st, ca, sa, sum;
		logic signed [15:0] joints[TWIST_COUNT];
		out_word_t w;
		joints = '{a.joint_1, a.joint_2, a.joint_3, a.joint_4, a.joint_5};
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				acc[r][c] = (r == c) ? 16384 : 0;
		for (int i = 0; i < TWIST_COUNT; i++) begin
			cordic_sincos(joints[i], ct, st);
			cordic_sincos(twist[i], ca, sa);
			lk[0][0] = ct; lk[0][1] = -st; lk[0][2] = 0;
			lk[1][0] = q14_product(st, ca); lk[1][1] = q14_product(ct, ca); lk[1][2] = -sa;
			lk[2][0] = q14_product(st, sa); lk[2][1] = q14_product(ct, sa); lk[2][2] = ca;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					sum = 0;
					for (int k = 0; k < 3; k++)
						sum += acc[r][k] * lk[k][c];
					nx[r][c] = clamp_unit(floor_shift(sum + 8192, 14));
				end
			acc = nx;
		end
		w.rot_r0c0 = 16'(acc[0][0]); w.rot_r0c1 = 16'(acc[0][1]); w.rot_r0c2 = 16'(acc[0][2]);
		w.rot_r1c0 = 16'(acc[1][0]); w.rot_r1c1 = 16'(acc[1][1]); w.rot_r1c2 = 16'(acc[1][2]);
		w.rot_r2c0 = 16'(acc[2][0]); w.rot_r2c1 = 16'(acc[2][1]); w.rot_r2c2 = 16'(acc[2][2]);
		return w;
	endfunction

	task automatic write_twist(int idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_data <= '{index: idx[IDX_BITS-1:0], data: val};
		do @(posedge clk); while (!cfg_ready);
		if (idx < TWIST_COUNT)
			twist[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_angles(in_word_t a, bit gaps);
		int n;
		if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			n = $urandom_range(1, 19);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= a;
		do @(posedge clk); while (!in_ready);
		board.note_angles(chain_orientation(a));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 7))
			0: return 16'sd25736;
			1: return -16'sd25736;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t a;
		a.joint_1 = rand_angle(); a.joint_2 = rand_angle(); a.joint_3 = rand_angle();
		a.joint_4 = rand_angle(); a.joint_5 = rand_angle();
		return a;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_matrix(out_data);
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 30);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		#20ms;
		$display("dh_chain_orientation regression: fail");
		$finish;
	end

	initial begin
		logic signed [15:0] edges[6];
		in_word_t a;
		arst_n <= 1'b0;
		edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, 16'sh7fff, 16'sh8000};
		board = new();
		twist = '{16'sd0, 16'sd12868, 16'sd0, 16'sd0, 16'sd12868};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset twists, edge angles
		foreach (edges[i]) begin
			a = '{edges[i], edges[i], edges[i], edges[i], edges[i]};
			send_angles(a, 1'b0);
		end
		send_angles('{16'sd12869, -16'sd12869, 16'sd25735, 16'sh5555, 16'shaaaa}, 1'b0);
		send_angles('{16'sd1, -16'sd1, 16'sd6434, -16'sd6434, 16'sd19302}, 1'b1);
		drain();

		// writes to invalid register indices; every twist is rewritten below before any word is sent
		write_twist(5, 16'h1234);
		write_twist(7, 16'hffff);
		for (int p = 0; p < 6; p++) begin
			for (int i = 0; i < TWIST_COUNT; i++)
				case (p)
					0: write_twist(i, 16'sd25736);
					1: write_twist(i, -16'sd25736);
					2: write_twist(i, 16'sh7fff);
					3: write_twist(i, 16'sh8000);
					default: write_twist(i, rand_angle());
				endcase
			for (int k = 0; k < 4; k++)
				send_angles(rand_word(), 1'b1);
			if (p == 4) begin
				hold_out = 1'b1;
				repeat (150) send_angles(rand_word(), 1'b0);
			end
			for (int k = 0; k < 275; k++)
				send_angles(rand_word(), 1'b1);
			drain();
		end
		write_twist(0, 16'sd0); write_twist(1, 16'sd12868); write_twist(2, -16'sd12868);
		write_twist(3, 16'sd3000); write_twist(4, 16'sd12868);
		quiet = 1'b1;
		for (int k = 0; k < 120; k++)
			send_angles(rand_word(), 1'b1);
		drain();

		if (board.errors == 0)
			$display("dh_chain_orientation regression: pass");
		else
			$display("dh_chain_orientation regression: fail");
		$finish;
	end
endmodule
